FILE: sv/sha1_pkg.sv
// ----------------------------------------------------------------------------
// SHA-1 digest package
// Shared payload types, constants and round helpers for the SHA-1 digest block.
// ----------------------------------------------------------------------------
package sha1_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       last;
    } sha1_in_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } sha1_out_t;

    // Entry of the queue between front and back: a byte to absorb, a request
    // to finish the message, or both.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       last;
    } sha1_cmd_t;

    localparam int QueueDepth = 4;

    localparam logic [31:0] H0 = 32'h67452301;
    localparam logic [31:0] H1 = 32'hEFCDAB89;
    localparam logic [31:0] H2 = 32'h98BADCFE;
    localparam logic [31:0] H3 = 32'h10325476;
    localparam logic [31:0] H4 = 32'hC3D2E1F0;
    localparam logic [7:0]  PadByte = 8'h80;

    function automatic logic [31:0] round_k(input logic [6:0] t);
        logic [31:0] k;
        begin
            if (t < 7'd20)
                k = 32'h5A827999;
            else if (t < 7'd40)
                k = 32'h6ED9EBA1;
            else if (t < 7'd60)
                k = 32'h8F1BBCDC;
            else
                k = 32'hCA62C1D6;
            return k;
        end
    endfunction

    function automatic logic [31:0] round_f(input logic [6:0] t, input logic [31:0] b,
                                            input logic [31:0] c, input logic [31:0] d);
        logic [31:0] f;
        begin
            if (t < 7'd20)
                f = (b & c) | (~b & d);
            else if (t < 7'd40)
                f = b ^ c ^ d;
            else if (t < 7'd60)
                f = (b & c) | (b & d) | (c & d);
            else
                f = b ^ c ^ d;
            return f;
        end
    endfunction

endpackage

FILE: sv/sha1_message_digest.sv
// ----------------------------------------------------------------------------
// SHA-1 message digest
// Computes the SHA-1 digest of a byte stream and emits five digest words.
// ----------------------------------------------------------------------------
// One message byte is taken per transfer into a short queue, so the input
// keeps accepting while the back end works, until the queue is full. The
// back end absorbs one byte per cycle while idle; it takes no bytes while a
// full 64-byte block runs through the single round unit and the chaining
// update. A closing transfer pads one byte per cycle to the end of the
// block (one or two blocks), then presents the five digest words one
// transfer each and returns to the initial chaining values.
module sha1_message_digest (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  sha1_pkg::sha1_in_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output sha1_pkg::sha1_out_t out_data
);
    import sha1_pkg::*;

    logic      cmd_valid, cmd_ready;
    sha1_cmd_t cmd_item;

    sha1_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_data),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd_item  (cmd_item)
    );

    sha1_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd_item  (cmd_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_data)
    );

endmodule

FILE: sv/sha1_front.sv
// ----------------------------------------------------------------------------
// SHA-1 front queue
// Accepts input items, drops those that carry neither flag, and queues the
// rest for the back end.
// ----------------------------------------------------------------------------
module sha1_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  sha1_pkg::sha1_in_t  in_item,
    output logic                cmd_valid,
    input  logic                cmd_ready,
    output sha1_pkg::sha1_cmd_t cmd_item
);
    import sha1_pkg::*;

    localparam int PtrW = $clog2(QueueDepth);

    sha1_cmd_t       mem_reg [QueueDepth];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PtrW:0]   count_reg, count_next;
    logic            push, pop, keep;

    assign in_ready  = (count_reg != QueueDepth[PtrW:0]);
    assign keep      = in_item.byte_valid | in_item.last;
    assign push      = in_valid & in_ready & keep;
    assign cmd_valid = (count_reg != '0);
    assign pop       = cmd_valid & cmd_ready;
    assign cmd_item  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + {{PtrW{1'b0}}, push} - {{PtrW{1'b0}}, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= in_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: sv/sha1_core.sv
// ----------------------------------------------------------------------------
// SHA-1 back end
// Packs bytes into the block buffer, pads, runs the 80 rounds one per cycle
// with a 16-word schedule window, and emits the five digest words.
// ----------------------------------------------------------------------------
module sha1_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_ready,
    input  sha1_pkg::sha1_cmd_t cmd_item,
    output logic                out_valid,
    input  logic                out_ready,
    output sha1_pkg::sha1_out_t out_item
);
    import sha1_pkg::*;

    localparam logic [2:0] StIdle  = 3'd0;
    localparam logic [2:0] StPad   = 3'd1;
    localparam logic [2:0] StRound = 3'd2;
    localparam logic [2:0] StAdd   = 3'd3;
    localparam logic [2:0] StEmit  = 3'd4;

    logic [2:0]  state_reg, state_next;
    logic [60:0] len_reg, len_next;
    logic [63:0] bits_reg, bits_next;
    logic        fin_reg, fin_next;
    logic        pad_reg, pad_next;
    logic        tail_reg, tail_next;
    logic [31:0] w_reg [16];
    logic [31:0] h_reg [5];
    logic [31:0] a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [6:0]  rnd_reg;
    logic [2:0]  idx_reg;

    logic        absorb;
    logic [7:0]  abs_byte;
    logic [5:0]  pos;
    logic [31:0] wt, wnew, tsum;

    assign pos       = len_reg[5:0];
    assign cmd_ready = (state_reg == StIdle);
    assign out_valid = (state_reg == StEmit);
    assign out_item.digest_word = h_reg[idx_reg];
    assign out_item.word_index  = idx_reg;
    assign out_item.last_word   = (idx_reg == 3'd4);

    // Byte fed into the buffer this cycle, from the queue or from padding.
    // The pad byte is still owed when the closing transfer also carried data,
    // and the length only goes into the block that ends the message.
    always_comb
    begin
        absorb   = 1'b0;
        abs_byte = cmd_item.data_byte;
        if (state_reg == StIdle && cmd_valid && cmd_item.byte_valid)
            absorb = 1'b1;
        else if (state_reg == StIdle && cmd_valid && cmd_item.last)
        begin
            absorb   = 1'b1;
            abs_byte = PadByte;
        end
        else if (state_reg == StPad)
        begin
            absorb = 1'b1;
            if (pad_reg)
                abs_byte = PadByte;
            else if (tail_reg && pos >= 6'd56)
                abs_byte = bits_reg[63 - 8 * (pos - 6'd56) -: 8];
            else
                abs_byte = 8'h00;
        end
    end

    assign wt   = w_reg[0];
    assign wnew = {w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0]} << 1
                | {w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0]} >> 31;
    assign tsum = {a_reg[26:0], a_reg[31:27]} + round_f(rnd_reg, b_reg, c_reg, d_reg)
                + e_reg + round_k(rnd_reg) + wt;

    always_comb
    begin
        state_next = state_reg;
        len_next   = absorb ? len_reg + 61'd1 : len_reg;
        bits_next  = bits_reg;
        fin_next   = fin_reg;
        pad_next   = pad_reg;
        tail_next  = tail_reg;
        unique case (state_reg)
            StIdle:
            begin
                if (cmd_valid)
                begin
                    if (cmd_item.byte_valid)
                    begin
                        fin_next = cmd_item.last;
                        if (cmd_item.last)
                        begin
                            bits_next = {len_reg + 61'd1, 3'b000};
                            pad_next  = 1'b1;
                            tail_next = ((pos + 6'd1) < 6'd56);
                        end
                        if (pos == 6'd63)
                            state_next = StRound;
                        else if (cmd_item.last)
                            state_next = StPad;
                    end
                    else
                    begin
                        // Last with no byte: the pad byte goes in now.
                        bits_next  = {len_reg, 3'b000};
                        fin_next   = 1'b1;
                        pad_next   = 1'b0;
                        tail_next  = (pos < 6'd56);
                        state_next = (pos == 6'd63) ? StRound : StPad;
                    end
                end
            end
            StPad:
            begin
                pad_next = 1'b0;
                if (pos == 6'd63)
                    state_next = StRound;
            end
            StRound:
                if (rnd_reg == 7'd79)
                    state_next = StAdd;
            StAdd:
            begin
                if (fin_reg && tail_reg && !pad_reg)
                    state_next = StEmit;
                else if (fin_reg)
                begin
                    tail_next  = 1'b1;
                    state_next = StPad;
                end
                else
                    state_next = StIdle;
            end
            StEmit:
                if (out_ready && idx_reg == 3'd4)
                begin
                    len_next   = '0;
                    fin_next   = 1'b0;
                    state_next = StIdle;
                end
            default:
                state_next = StIdle;
        endcase
    end

    // Schedule window and block buffer: bytes shift into the word window;
    // during rounds the window rolls with the new schedule word.
    always_ff @(posedge clk)
    begin
        if (absorb)
            w_reg[pos[5:2]] <= {w_reg[pos[5:2]][23:0], abs_byte};
        else if (state_reg == StRound)
        begin
            for (int i = 0; i < 15; i++)
                w_reg[i] <= w_reg[i + 1];
            w_reg[15] <= wnew;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= StIdle;
            len_reg   <= '0;
            bits_reg  <= '0;
            fin_reg   <= 1'b0;
            pad_reg   <= 1'b0;
            tail_reg  <= 1'b0;
            rnd_reg   <= '0;
            idx_reg   <= '0;
            h_reg[0]  <= H0;
            h_reg[1]  <= H1;
            h_reg[2]  <= H2;
            h_reg[3]  <= H3;
            h_reg[4]  <= H4;
            a_reg     <= '0;
            b_reg     <= '0;
            c_reg     <= '0;
            d_reg     <= '0;
            e_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            len_reg   <= len_next;
            bits_reg  <= bits_next;
            fin_reg   <= fin_next;
            pad_reg   <= pad_next;
            tail_reg  <= tail_next;
            if (state_next == StRound && state_reg != StRound)
            begin
                rnd_reg <= '0;
                a_reg   <= h_reg[0];
                b_reg   <= h_reg[1];
                c_reg   <= h_reg[2];
                d_reg   <= h_reg[3];
                e_reg   <= h_reg[4];
            end
            else if (state_reg == StRound)
            begin
                rnd_reg <= rnd_reg + 7'd1;
                a_reg   <= tsum;
                b_reg   <= a_reg;
                c_reg   <= {b_reg[1:0], b_reg[31:2]};
                d_reg   <= c_reg;
                e_reg   <= d_reg;
            end
            if (state_reg == StAdd)
            begin
                h_reg[0] <= h_reg[0] + a_reg;
                h_reg[1] <= h_reg[1] + b_reg;
                h_reg[2] <= h_reg[2] + c_reg;
                h_reg[3] <= h_reg[3] + d_reg;
                h_reg[4] <= h_reg[4] + e_reg;
                idx_reg  <= '0;
            end
            if (state_reg == StEmit && out_ready)
            begin
                idx_reg <= idx_reg + 3'd1;
                if (idx_reg == 3'd4)
                begin
                    h_reg[0] <= H0;
                    h_reg[1] <= H1;
                    h_reg[2] <= H2;
                    h_reg[3] <= H3;
                    h_reg[4] <= H4;
                end
            end
        end
    end

endmodule
